// File: rtl/cau_pkg.sv
// cau_pkg: shared constants, command codes and status codes
// for the complex arithmetic unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CMD_BITS = 4;
  localparam int STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_EQ = 4'd4, CMD_NE = 4'd5, CMD_NEG = 4'd6, CMD_CONJ = 4'd7,
    CMD_ABS = 4'd8
  } cmd_t;

  localparam logic [STATUS_BITS-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_SAT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_DIV0 = 2'd2;
endpackage
`default_nettype wire

// File: rtl/cau_mul.sv
// cau_mul: serial signed multiplier, one multiplier bit per cycle
// uses cau_pkg; result is full 2W-bit signed product
`timescale 1ns / 1ps
`default_nettype none
module cau_mul #(
  parameter int W = cau_pkg::WORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic signed [W-1:0] x,
  input  wire logic signed [W-1:0] y,
  output logic                     done,
  output logic signed [2*W-1:0]    p
);
  import cau_pkg::*;
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] mx, my;
  logic [2*W-1:0] acc;
  logic [CW-1:0] cnt;
  logic busy, neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mx <= x[W-1] ? W'(-x) : x;
        my <= y[W-1] ? W'(-y) : y;
        neg <= x[W-1] ^ y[W-1];
        acc <= '0;
        cnt <= '0;
      end else if (busy) begin
        // shift-add from the top multiplier bit down
        acc <= (acc << 1) + (my[W-1] ? {{W{1'b0}}, mx} : '0);
        my <= my << 1;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign p = neg ? -$signed(acc) : $signed(acc);
endmodule
`default_nettype wire

// File: rtl/cau_div.sv
// cau_div: restoring divider, one quotient bit per cycle
// uses cau_pkg; unsigned magnitudes, sign applied by caller
`timescale 1ns / 1ps
`default_nettype none
module cau_div #(
  parameter int NB = 3 * cau_pkg::WORD_BITS_DEF + 2,
  parameter int DB = 2 * cau_pkg::WORD_BITS_DEF + 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NB-1:0] n,
  input  wire logic [DB-1:0] d,
  output logic               done,
  output logic [NB-1:0]      q
);
  import cau_pkg::*;
  localparam int CW = $clog2(NB + 1);
  logic [NB-1:0] nsh;
  logic [DB:0] rem;
  logic [DB:0] trial;
  logic [CW-1:0] cnt;
  logic busy;

  assign trial = {rem[DB-1:0], nsh[NB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        nsh <= n;
        rem <= '0;
        q <= '0;
        cnt <= '0;
      end else if (busy) begin
        nsh <= nsh << 1;
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q <= {q[NB-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NB-2:0], 1'b0};
        end
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/complex_arithmetic_unit.sv
// complex_arithmetic_unit: top level, command sequencer with shared
// serial multiplier and serial divider; uses cau_pkg, cau_mul, cau_div
//
// channel | dir | signals
// in      | in  | in_valid in_ready command a_re a_im b_re b_im a_from_prev b_from_prev
// out     | out | out_valid out_ready res_re res_im truth status
//
// add, sub, neg, conj, eq, ne: no serial products, straight from idle to finish
// mul: four serial products
// abs_sqd: two serial products
// div: six serial products then, unless the divisor is zero, two restoring
//   divides of 3*W+2 bits each
// one request at a time; in_ready is high only when idle with the output empty
// or being taken; synchronous reset loads prev answer 0+1i
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cau_pkg::CMD_BITS-1:0]  command,
  input  wire logic signed [WORD_BITS-1:0]   a_re,
  input  wire logic signed [WORD_BITS-1:0]   a_im,
  input  wire logic signed [WORD_BITS-1:0]   b_re,
  input  wire logic signed [WORD_BITS-1:0]   b_im,
  input  wire logic                          a_from_prev,
  input  wire logic                          b_from_prev,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [WORD_BITS-1:0]        res_re,
  output logic signed [WORD_BITS-1:0]        res_im,
  output logic                               truth,
  output logic [cau_pkg::STATUS_BITS-1:0]    status
);
  import cau_pkg::*;
  localparam int W = WORD_BITS;
  localparam int P = 2 * W + 2;     // sum of two products
  localparam int NB = 3 * W + 2;    // dividend magnitude width
  localparam int DB = P;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIVGO, S_DIVW, S_FIN} state_t;
  state_t state;

  logic [CMD_BITS-1:0] cmd;
  logic signed [W-1:0] ar, ai, br, bi, prev_re, prev_im;
  logic [2:0] step;
  logic signed [P-1:0] acc0, acc1, acc2;
  logic mul_start, mul_done, div_start, div_done, div_part;
  logic signed [W-1:0] mx, my;
  logic signed [2*W-1:0] prod;
  logic [NB-1:0] div_n, div_q;
  logic [DB-1:0] div_d;
  logic signed [NB:0] qr, qi;

  cau_mul #(.W(W)) u_mul (.clk(clk), .rst(rst), .start(mul_start), .x(mx), .y(my),
    .done(mul_done), .p(prod));
  cau_div #(.NB(NB), .DB(DB)) u_div (.clk(clk), .rst(rst), .start(div_start),
    .n(div_n), .d(div_d), .done(div_done), .q(div_q));

  // operand pair per product step
  always_comb begin
    mx = ar;
    my = br;
    case (step)
      3'd0: begin mx = ar; my = (cmd == CMD_ABS) ? ar : br; end
      3'd1: begin mx = ai; my = (cmd == CMD_ABS) ? ai : bi; end
      3'd2: begin mx = ar; my = bi; end
      3'd3: begin mx = ai; my = br; end
      3'd4: begin mx = br; my = br; end
      3'd5: begin mx = bi; my = bi; end
      default: begin mx = ar; my = br; end
    endcase
  end

  // shifted numerators and divisor
  logic signed [P-1:0] nr_s, ni_s, d_s;
  logic signed [NB-1:0] num;
  assign nr_s = acc0 >>> FRAC_BITS;
  assign ni_s = acc1 >>> FRAC_BITS;
  assign d_s = acc2 >>> FRAC_BITS;
  assign num = div_part ? (NB'(ni_s) <<< FRAC_BITS) : (NB'(nr_s) <<< FRAC_BITS);
  assign div_n = num[NB-1] ? NB'(-num) : NB'(num);
  assign div_d = DB'(d_s);

  function automatic logic [W-1:0] sat(input logic signed [NB:0] v, inout logic s);
    logic signed [NB:0] mxv, mnv;
    mxv = (NB+1)'({1'b0, {(W-1){1'b1}}});
    mnv = -mxv - (NB+1)'(1);
    if (v > mxv) begin s = 1'b1; return {1'b0, {(W-1){1'b1}}}; end
    if (v < mnv) begin s = 1'b1; return {1'b1, {(W-1){1'b0}}}; end
    return v[W-1:0];
  endfunction

  logic signed [NB:0] fr, fi;
  logic [W-1:0] sr, si;
  logic fsat, fhas, fupd, fdz, ftruth;
  always_comb begin
    fr = '0; fi = '0; fhas = 1'b0; fupd = 1'b0; fdz = 1'b0; ftruth = 1'b0;
    fsat = 1'b0;
    case (cmd)
      CMD_ADD: begin fr = (NB+1)'(ar) + (NB+1)'(br); fi = (NB+1)'(ai) + (NB+1)'(bi);
        fhas = 1'b1; fupd = 1'b1; end
      CMD_SUB: begin fr = (NB+1)'(ar) - (NB+1)'(br); fi = (NB+1)'(ai) - (NB+1)'(bi);
        fhas = 1'b1; fupd = 1'b1; end
      CMD_MUL: begin fr = (NB+1)'(nr_s); fi = (NB+1)'(ni_s); fhas = 1'b1; fupd = 1'b1; end
      CMD_DIV: begin
        if (d_s == '0) fdz = 1'b1;
        else begin fr = qr; fi = qi; fhas = 1'b1; fupd = 1'b1; end
      end
      CMD_EQ: ftruth = (ar == br) && (ai == bi);
      CMD_NE: ftruth = (ar != br) || (ai != bi);
      CMD_NEG: begin fr = -(NB+1)'(ar); fi = -(NB+1)'(ai); fhas = 1'b1; fupd = 1'b1; end
      CMD_CONJ: begin fr = (NB+1)'(ar); fi = -(NB+1)'(ai); fhas = 1'b1; fupd = 1'b1; end
      CMD_ABS: begin fr = (NB+1)'(nr_s); fhas = 1'b1; end
      default: ;
    endcase
    sr = sat(fr, fsat);
    si = sat(fi, fsat);
    if (!fhas) begin sr = '0; si = '0; fsat = 1'b0; end
  end

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  // start pulses for the serial units
  logic long_cmd, fin_mul, mul_start_next, div_start_next;
  assign long_cmd = (command == CMD_MUL) || (command == CMD_DIV) || (command == CMD_ABS);
  assign fin_mul = ((cmd == CMD_ABS) && (step == 3'd1)) ||
                   ((cmd == CMD_MUL) && (step == 3'd3));
  assign mul_start_next = ((state == S_IDLE) && in_valid && in_ready && long_cmd) ||
                          ((state == S_MUL) && mul_done && !fin_mul && (step != 3'd5));
  assign div_start_next = (state == S_DIVGO) && (d_s != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      prev_re <= '0;
      prev_im <= W'(1) << FRAC_BITS;
    end else begin
      mul_start <= mul_start_next;
      div_start <= div_start_next;
      if (out_valid && out_ready && (state != S_FIN)) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          cmd <= command;
          ar <= a_from_prev ? prev_re : a_re;
          ai <= a_from_prev ? prev_im : a_im;
          br <= b_from_prev ? prev_re : b_re;
          bi <= b_from_prev ? prev_im : b_im;
          step <= '0;
          acc0 <= '0; acc1 <= '0; acc2 <= '0;
          if (long_cmd) state <= S_MUL;
          else state <= S_FIN;
        end
        S_MUL: if (mul_done) begin
          // accumulate the product according to command and step
          case (step)
            3'd0: acc0 <= P'(prod);
            3'd1: acc0 <= (cmd == CMD_MUL) ? acc0 - P'(prod) : acc0 + P'(prod);
            3'd2: acc1 <= (cmd == CMD_MUL) ? P'(prod) : -P'(prod);
            3'd3: acc1 <= acc1 + P'(prod);
            3'd4: acc2 <= P'(prod);
            default: acc2 <= acc2 + P'(prod);
          endcase
          if (fin_mul)
            state <= S_FIN;
          else if (step == 3'd5) begin
            div_part <= 1'b0;
            state <= S_DIVGO;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_DIVGO: begin
          if (d_s == '0) state <= S_FIN;
          else state <= S_DIVW;
        end
        S_DIVW: if (div_done) begin
          if (!div_part) begin
            qr <= nr_s[P-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
            div_part <= 1'b1;
            state <= S_DIVGO;
          end else begin
            qi <= ni_s[P-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
            state <= S_FIN;
          end
        end
        S_FIN: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          res_re <= sr;
          res_im <= si;
          truth <= ftruth;
          status <= fdz ? ST_DIV0 : (fsat ? ST_SAT : ST_OK);
          if (fupd) begin prev_re <= sr; prev_im <= si; end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_re) && $stable(status)))
    else $error("result dropped");
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DIV0) |-> (res_re == '0 && res_im == '0))
    else $error("div by zero result not zero");
  a_truth_cmp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truth) |-> (status == ST_OK && res_re == '0))
    else $error("truth with value");
`endif
endmodule
`default_nettype wire
